[rtl/core/mcsm_pkg.sv]
// ----------------------------------------------------------------------------
// Motion command safety monitor package
// Shared constants and types for the safety monitor core.
// ----------------------------------------------------------------------------
package mcsm_pkg;

    localparam int unsigned MOTORS_DEF = 16;
    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam logic [31:0] PERIOD_RESET = 32'd4294967;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_CHECK = 2'd1;
    localparam logic [1:0] REQ_STORE = 2'd2;
    localparam logic [1:0] REQ_FIX   = 2'd3;

    localparam logic [7:0] EN_MASK  = 8'h6f;
    localparam logic [7:0] EN_VALUE = 8'h27;

    localparam logic signed [7:0] MODE_PP  = 8'sd1;
    localparam logic signed [7:0] MODE_HM  = 8'sd6;
    localparam logic signed [7:0] MODE_CSP = 8'sd8;
    localparam logic signed [7:0] MODE_CSV = 8'sd9;
    localparam logic signed [7:0] MODE_CST = 8'sd10;

    localparam logic [2:0] LIM_MAXPOS = 3'd0;
    localparam logic [2:0] LIM_MINPOS = 3'd1;
    localparam logic [2:0] LIM_MAXVEL = 3'd2;
    localparam logic [2:0] LIM_MINVEL = 3'd3;
    localparam logic [2:0] LIM_MAXACC = 3'd4;
    localparam logic [2:0] LIM_MINACC = 3'd5;
    localparam logic [2:0] LIM_POSFE  = 3'd6;
    localparam logic [2:0] LIM_VELFE  = 3'd7;

    localparam logic [3:0] ERR_OK      = 4'd0;
    localparam logic [3:0] ERR_DISABLE = 4'd1;
    localparam logic [3:0] ERR_POS_MAX = 4'd2;
    localparam logic [3:0] ERR_POS_MIN = 4'd3;
    localparam logic [3:0] ERR_POS_D1  = 4'd4;
    localparam logic [3:0] ERR_POS_D2  = 4'd5;
    localparam logic [3:0] ERR_POS_FE  = 4'd6;
    localparam logic [3:0] ERR_VEL_MAX = 4'd7;
    localparam logic [3:0] ERR_VEL_MIN = 4'd8;
    localparam logic [3:0] ERR_VEL_D1  = 4'd9;
    localparam logic [3:0] ERR_VEL_FE  = 4'd10;
    localparam logic [3:0] ERR_MODE    = 4'd11;

    // Difference operands are kept at 34 bits so that tp + pp - 2*lp never wraps.
    localparam int unsigned DW = 34;

    // Kinds of test the shared unit runs.
    typedef enum logic [1:0] {
        T_GT,     // a > limit
        T_LT,     // a < limit
        T_SCALED  // a outside [k*lo, k*hi], two steps
    } t_test;

endpackage

[rtl/core/motion_command_safety_monitor.sv]
// ----------------------------------------------------------------------------
// Motion command safety monitor
// Per-motor check of drive commands against a limit table and history.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_axis    in         request: type, motor, limit, status, mode, targets
//  m_axis    out        result: fault code, fixed targets, torque/disable flags
//  cfg       in         sample period, unsigned Q0.32 seconds
//
// A request is taken only while the sequencer is idle and the output register
// is free. Each request is decoded first. A load, a store, a motor out of
// range or a check that runs no limit test then goes to the output register;
// a fix first reads the following-error limit. A check steps through the
// tests of its mode, passing over skipped ones, reads each limit through the
// memory read port and runs a scaled test on the single shared multiplier,
// upper bound first. It stops at the first test that fails. The input reopens
// in the cycle after the result transfer. At reset the period register takes
// its default and the position and velocity history is zero; the limit memory
// is not cleared. A stalled output holds the result and keeps the block from
// taking a new request.
//
module motion_command_safety_monitor
    import mcsm_pkg::*;
#(
    parameter int unsigned MOTORS      = MOTORS_DEF,
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: req_type[2], motor[4], limit_sel[3], limit_value[32],
    // status_word[16], op_mode[8], target_pos[32], target_vel[32],
    // actual_pos[32], actual_vel[32], skip_mask[11], zero fill to 208 bits
    input  logic [207:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: fault_code[4], fixed_pos[32], fixed_vel[32],
    // zero_torque[1], disable_request[1], zero fill to 72 bits
    output logic [71:0]  m_axis_tdata
);

    localparam int unsigned MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int unsigned AW = MW + 3;
    localparam int unsigned VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD, S_TEST, S_MUL1, S_MUL2, S_FIXRD, S_FIXW, S_OUT
    } t_state;

    // Sign-extend a value carried at VW bits to the difference width.
    function automatic logic signed [DW-1:0] vx(input logic [31:0] v);
        logic [31:0] t;
        t = v << (32 - VW);
        return DW'($signed(t) >>> (32 - VW));
    endfunction

    function automatic logic [31:0] venc(input logic signed [DW-1:0] v);
        logic [31:0] m;
        m = 32'hffff_ffff >> (32 - VW);
        return v[31:0] & m;
    endfunction

    // Input fields.
    logic [1:0]  f_req;
    logic [3:0]  f_motor;
    logic [2:0]  f_sel;
    logic [31:0] f_lv, f_tp, f_tv, f_ap, f_av;
    logic [15:0] f_sw;
    logic [7:0]  f_mode;
    logic [10:0] f_sk;
    assign f_req   = s_axis_tdata[1:0];
    assign f_motor = s_axis_tdata[5:2];
    assign f_sel   = s_axis_tdata[8:6];
    assign f_lv    = s_axis_tdata[40:9];
    assign f_sw    = s_axis_tdata[56:41];
    assign f_mode  = s_axis_tdata[64:57];
    assign f_tp    = s_axis_tdata[96:65];
    assign f_tv    = s_axis_tdata[128:97];
    assign f_ap    = s_axis_tdata[160:129];
    assign f_av    = s_axis_tdata[192:161];
    assign f_sk    = s_axis_tdata[203:193];

    // Latched request.
    logic [1:0]  r_req;
    logic [MW-1:0] r_m;
    logic        r_mok;
    logic [2:0]  r_sel;
    logic [31:0] r_lv, r_tp, r_tv, r_ap, r_av;
    logic        r_en;
    logic signed [7:0] r_mode;
    logic [10:0] r_sk;

    logic [31:0] r_period;
    logic [31:0] r_dt2;

    // Limit memory and per-motor history.
    logic [31:0] mem_lim [0:MOTORS*8-1];
    logic [31:0] r_rdata;
    logic [31:0] r_last [0:MOTORS-1];
    logic [31:0] r_prev [0:MOTORS-1];
    logic [31:0] r_lvel [0:MOTORS-1];

    t_state r_state;
    logic [3:0] r_step;
    logic       r_half;
    logic signed [DW-1:0] r_opnd;
    logic [2:0] r_lsel;
    t_test      r_kind;
    logic [3:0] r_cand;
    logic       r_guard;
    logic       r_valid;
    logic [3:0]  r_oerr;
    logic [31:0] r_ofp, r_ofv;
    logic        r_ozt, r_odis;

    logic        rd_en;
    logic [AW-1:0] rd_addr;

    // Step table: for the mode, which test is step r_step.
    logic        st_have;
    logic [3:0]  st_code;
    logic [2:0]  st_sel;
    t_test       st_kind;
    logic signed [DW-1:0] st_op;
    logic        st_dt2;
    // Extra condition of a compare test; position limits in position mode
    // only trip when the target also moves further out than the last one.
    logic        st_guard;

    logic signed [DW-1:0] tp_x, tv_x, ap_x, av_x, lp_x, pp_x, lvel_x;
    assign tp_x   = vx(r_tp);
    assign tv_x   = vx(r_tv);
    assign ap_x   = vx(r_ap);
    assign av_x   = vx(r_av);
    assign lp_x   = vx(r_last[r_m]);
    assign pp_x   = vx(r_prev[r_m]);
    assign lvel_x = vx(r_lvel[r_m]);

    always_comb begin
        st_have  = 1'b0;
        st_code  = ERR_OK;
        st_sel   = LIM_MAXPOS;
        st_kind  = T_GT;
        st_op    = '0;
        st_dt2   = 1'b0;
        st_guard = 1'b1;
        if (r_mode == MODE_CSP) begin
            unique case (r_step)
                4'd0: begin st_have = 1'b1; st_code = ERR_POS_MAX; st_sel = LIM_MAXPOS;
                    st_kind = T_GT; st_op = tp_x; st_guard = tp_x > lp_x; end
                4'd1: begin st_have = 1'b1; st_code = ERR_POS_MIN; st_sel = LIM_MINPOS;
                    st_kind = T_LT; st_op = tp_x; st_guard = tp_x < lp_x; end
                4'd2: begin st_have = 1'b1; st_code = ERR_POS_D1; st_sel = LIM_MAXVEL;
                    st_kind = T_SCALED; st_op = tp_x - lp_x; end
                4'd3: begin st_have = 1'b1; st_code = ERR_POS_D2; st_sel = LIM_MAXACC;
                    st_kind = T_SCALED; st_op = tp_x + pp_x - (lp_x <<< 1);
                    st_dt2 = 1'b1; end
                4'd4: begin st_have = 1'b1; st_code = ERR_POS_FE; st_sel = LIM_POSFE;
                    st_kind = T_GT;
                    st_op = (tp_x - ap_x < 0) ? ap_x - tp_x : tp_x - ap_x; end
                default: ;
            endcase
        end else if (r_mode == MODE_CSV) begin
            unique case (r_step)
                4'd0: begin st_have = 1'b1; st_code = ERR_VEL_MAX; st_sel = LIM_MAXVEL;
                    st_kind = T_GT; st_op = tv_x; end
                4'd1: begin st_have = 1'b1; st_code = ERR_VEL_MIN; st_sel = LIM_MINVEL;
                    st_kind = T_LT; st_op = tv_x; end
                4'd2: begin st_have = 1'b1; st_code = ERR_VEL_D1; st_sel = LIM_MAXACC;
                    st_kind = T_SCALED; st_op = tv_x - lvel_x; end
                4'd3: begin st_have = 1'b1; st_code = ERR_VEL_FE; st_sel = LIM_VELFE;
                    st_kind = T_GT;
                    st_op = (tv_x - av_x < 0) ? av_x - tv_x : tv_x - av_x; end
                default: ;
            endcase
        end else if (r_mode == MODE_CST) begin
            unique case (r_step)
                4'd0: begin st_have = 1'b1; st_code = ERR_POS_MAX; st_sel = LIM_MAXPOS;
                    st_kind = T_GT; st_op = ap_x; end
                4'd1: begin st_have = 1'b1; st_code = ERR_POS_MIN; st_sel = LIM_MINPOS;
                    st_kind = T_LT; st_op = ap_x; end
                4'd2: begin st_have = 1'b1; st_code = ERR_VEL_MAX; st_sel = LIM_MAXVEL;
                    st_kind = T_GT; st_op = av_x; end
                4'd3: begin st_have = 1'b1; st_code = ERR_VEL_MIN; st_sel = LIM_MINVEL;
                    st_kind = T_LT; st_op = av_x; end
                4'd4: begin st_have = 1'b1; st_code = ERR_VEL_D1; st_sel = LIM_MAXACC;
                    st_kind = T_SCALED; st_op = av_x - lvel_x; end
                default: ;
            endcase
        end
    end

    // Shared multiplier: period squared, then period or its square by a limit.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic signed [DW-1:0] lim_x;
    logic        lim_neg;
    logic [32:0] lim_mag;
    assign lim_x   = vx(r_rdata);
    assign lim_neg = lim_x < 0;
    assign lim_mag = lim_neg ? 33'(-lim_x) : 33'(lim_x);
    logic r_usedt2;
    logic r_mneg;
    assign mul_a = (r_state == S_DEC) ? r_period : (r_usedt2 ? r_dt2 : r_period);
    assign mul_b = (r_state == S_DEC) ? r_period : lim_mag[31:0];

    mcsm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // A magnitude with bit 32 set skips the multiplier and gives k << 31.
    logic [64:0] prod;
    logic        r_big;
    assign prod = r_big ? (65'(r_usedt2 ? r_dt2 : r_period) << 31) : 65'(mul_p);
    logic signed [DW-1:0] p_fl, p_ce, sc_fl, sc_ce;
    assign p_fl  = DW'(prod[64:32]);
    assign p_ce  = p_fl + DW'(prod[31:0] != 32'd0);
    assign sc_fl = r_mneg ? -p_ce : p_fl;
    assign sc_ce = r_mneg ? -p_fl : p_ce;

    logic skip_now;
    assign skip_now = r_sk[st_code - 4'd1];

    assign s_axis_tready = (r_state == S_IDLE) && !r_valid;
    assign rd_addr = AW'({r_m, r_lsel});

    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC && r_req == REQ_LOAD && r_mok) begin
            mem_lim[rd_addr] <= venc(vx(r_lv));
        end
        if (rd_en) begin
            r_rdata <= mem_lim[rd_addr];
        end
    end
    assign rd_en = (r_state == S_RD) || (r_state == S_FIXRD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_period <= PERIOD_RESET;
            for (int i = 0; i < MOTORS; i++) begin
                r_last[i] <= '0;
                r_prev[i] <= '0;
                r_lvel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (r_valid && m_axis_tready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req  <= f_req;
                        r_m    <= MW'(f_motor);
                        r_mok  <= 32'(f_motor) < MOTORS;
                        r_lsel <= f_sel;
                        r_lv   <= f_lv;
                        r_tp   <= f_tp;
                        r_tv   <= f_tv;
                        r_ap   <= f_ap;
                        r_av   <= f_av;
                        r_en   <= (f_sw[7:0] & EN_MASK) == EN_VALUE;
                        r_mode <= f_mode;
                        r_sk   <= f_sk;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    // Multiplier forms period squared this cycle.
                    r_step <= '0;
                    r_oerr <= ERR_OK;
                    r_ofp  <= '0;
                    r_ofv  <= '0;
                    r_ozt  <= 1'b0;
                    r_odis <= 1'b0;
                    r_big  <= 1'b0;
                    if (!r_mok) begin
                        r_state <= S_OUT;
                    end else begin
                        unique case (r_req)
                            REQ_LOAD: r_state <= S_OUT;
                            REQ_STORE: begin
                                r_prev[r_m] <= r_last[r_m];
                                r_last[r_m] <= venc(tp_x);
                                r_lvel[r_m] <= venc(tv_x);
                                r_state <= S_OUT;
                            end
                            REQ_FIX: begin
                                r_lsel  <= LIM_POSFE;
                                r_state <= S_FIXRD;
                            end
                            default: begin
                                if (!r_en) begin
                                    r_oerr  <= r_sk[0] ? ERR_OK : ERR_DISABLE;
                                    r_state <= S_OUT;
                                end else if (r_mode == MODE_CSP || r_mode == MODE_CSV
                                        || r_mode == MODE_CST) begin
                                    r_state <= S_TEST;
                                end else begin
                                    r_oerr <= (r_mode == MODE_HM || r_sk[10])
                                              ? ERR_OK : ERR_MODE;
                                    r_state <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_TEST: begin
                    // Latch dt*dt once, then pick the next unskipped test.
                    if (r_step == 4'd0) begin
                        r_dt2 <= mul_p[63:32];
                    end
                    if (!st_have) begin
                        r_oerr  <= ERR_OK;
                        r_state <= S_OUT;
                    end else if (skip_now) begin
                        r_step <= r_step + 4'd1;
                    end else begin
                        r_lsel   <= st_sel;
                        r_kind   <= st_kind;
                        r_cand   <= st_code;
                        r_opnd   <= st_op;
                        r_guard  <= st_guard;
                        r_usedt2 <= st_dt2;
                        r_half   <= 1'b0;
                        r_state  <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    // Limit word is valid; plain compares finish here.
                    r_mneg <= lim_neg;
                    r_big  <= lim_mag[32];
                    if (r_kind == T_GT || r_kind == T_LT) begin
                        if (r_guard && ((r_kind == T_GT) ? (r_opnd > lim_x)
                                                         : (r_opnd < lim_x))) begin
                            r_oerr  <= r_cand;
                            r_state <= S_OUT;
                        end else begin
                            r_step  <= r_step + 4'd1;
                            r_state <= S_TEST;
                        end
                    end else begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    // Product of the limit read in the previous state is ready.
                    if (!r_half) begin
                        if (r_opnd > sc_fl) begin
                            r_oerr  <= r_cand;
                            r_state <= S_OUT;
                        end else begin
                            r_half  <= 1'b1;
                            r_lsel  <= r_lsel + 3'd1;
                            r_state <= S_RD;
                        end
                    end else if (r_opnd < sc_ce) begin
                        r_oerr  <= r_cand;
                        r_state <= S_OUT;
                    end else begin
                        r_step  <= r_step + 4'd1;
                        r_state <= S_TEST;
                    end
                end
                S_FIXRD: begin
                    r_state <= S_FIXW;
                end
                S_FIXW: begin
                    if (r_mode == MODE_PP || r_mode == MODE_CSP) begin
                        if (((lp_x - ap_x < 0) ? ap_x - lp_x : lp_x - ap_x) > lim_x) begin
                            r_ofp <= venc(ap_x);
                            r_last[r_m] <= venc(ap_x);
                            r_prev[r_m] <= venc(ap_x);
                        end else begin
                            r_ofp <= venc(lp_x);
                            r_last[r_m] <= venc(lp_x);
                            r_prev[r_m] <= venc(lp_x);
                        end
                        r_ofv <= venc(tv_x);
                        r_lvel[r_m] <= venc(tv_x);
                    end else if (r_mode == MODE_CSV) begin
                        r_ofp <= venc(tp_x);
                        r_last[r_m] <= venc(tp_x);
                        r_prev[r_m] <= venc(tp_x);
                        r_lvel[r_m] <= '0;
                    end else if (r_mode == MODE_CST) begin
                        r_ofp <= venc(tp_x);
                        r_ofv <= venc(tv_x);
                        r_last[r_m] <= venc(tp_x);
                        r_prev[r_m] <= venc(tp_x);
                        r_lvel[r_m] <= venc(tv_x);
                        r_ozt <= 1'b1;
                        r_odis <= 1'b1;
                    end else begin
                        r_last[r_m] <= '0;
                        r_prev[r_m] <= '0;
                        r_lvel[r_m] <= '0;
                        r_ozt <= 1'b1;
                        r_odis <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_odis, r_ozt, r_ofv, r_ofp, r_oerr};

endmodule

[rtl/core/mcsm_mul.sv]
// ----------------------------------------------------------------------------
// Motion command safety monitor multiplier
// Registered 32x32 unsigned multiplier shared by all scaled-limit tests.
// ----------------------------------------------------------------------------
module mcsm_mul
    import mcsm_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

[rtl/core/mcsm_checker.sv]
// ----------------------------------------------------------------------------
// Motion command safety monitor checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module mcsm_props
    import mcsm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [71:0]  m_axis_tdata
);

    // A new request is never taken while a result waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");

    // An accepted request cannot produce a result in the very next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");

    // Error codes stay within the defined range.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= ERR_MODE))
        else $error("bad error code");

    // A result held under stall keeps its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

endmodule

bind motion_command_safety_monitor mcsm_props u_mcsm_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/mcsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety monitor result checker
// Watches the request, result and period channels, keeps its own copy of the
// limit table and the per-motor history, and compares every result transfer
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mcsm_checker
    import mcsm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [207:0] i_req_data,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [71:0]  i_res_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results
);

    typedef struct packed {
        logic        dis;
        logic        zt;
        logic [31:0] fv;
        logic [31:0] fp;
        logic [3:0]  err;
    } t_verdict;

    logic [31:0]        period;
    logic signed [31:0] limits [128];
    logic signed [31:0] last_pos [16];
    logic signed [31:0] prev_pos [16];
    logic signed [31:0] last_vel [16];
    t_verdict           verdict_q [$];

    initial begin
        for (int i = 0; i < 128; i++) limits[i] = '0;
    end

    // Floor (up = 0) or ceiling (up = 1) of k * l / 2^32.
    function automatic longint scale(logic [31:0] k, longint l, bit up);
        logic [63:0] mag;
        logic [63:0] p;
        longint      f;
        longint      c;
        mag = (l < 0) ? 64'(-l) : 64'(l);
        p = mag * {32'd0, k};
        f = longint'(p >> 32);
        c = f + ((p[31:0] != 0) ? 1 : 0);
        if (l < 0) return up ? -f : -c;
        return up ? c : f;
    endfunction

    function automatic bit beyond(longint d, logic [31:0] k, longint hi, longint lo);
        return (d > scale(k, hi, 1'b0)) || (d < scale(k, lo, 1'b1));
    endfunction

    function automatic longint lim(logic [3:0] m, logic [2:0] sel);
        return longint'(limits[{m, sel}]);
    endfunction

    function automatic logic [3:0] check_code(logic [3:0] m, logic [15:0] sw,
                                              logic signed [7:0] mode,
                                              longint tp, longint tv,
                                              longint ap, longint av,
                                              logic [10:0] skip);
        bit          en;
        longint      lp;
        longint      pp;
        longint      lv;
        logic [63:0] sq;
        logic [31:0] dt2;
        en = ((sw[7:0] & EN_MASK) == EN_VALUE);
        lp = longint'(last_pos[m]);
        pp = longint'(prev_pos[m]);
        lv = longint'(last_vel[m]);
        sq = {32'd0, period} * {32'd0, period};
        dt2 = sq[63:32];
        if (!skip[ERR_DISABLE - 1] && !en) return ERR_DISABLE;
        if (!en || mode == MODE_HM) return ERR_OK;
        if (mode == MODE_CSP) begin
            if (!skip[ERR_POS_MAX - 1] && tp > lim(m, LIM_MAXPOS) && tp > lp)
                return ERR_POS_MAX;
            if (!skip[ERR_POS_MIN - 1] && tp < lim(m, LIM_MINPOS) && tp < lp)
                return ERR_POS_MIN;
            if (!skip[ERR_POS_D1 - 1] &&
                beyond(tp - lp, period, lim(m, LIM_MAXVEL), lim(m, LIM_MINVEL)))
                return ERR_POS_D1;
            if (!skip[ERR_POS_D2 - 1] &&
                beyond(tp + pp - 2 * lp, dt2, lim(m, LIM_MAXACC), lim(m, LIM_MINACC)))
                return ERR_POS_D2;
            if (!skip[ERR_POS_FE - 1] &&
                ((tp > ap) ? tp - ap : ap - tp) > lim(m, LIM_POSFE))
                return ERR_POS_FE;
            return ERR_OK;
        end
        if (mode == MODE_CSV) begin
            if (!skip[ERR_VEL_MAX - 1] && tv > lim(m, LIM_MAXVEL)) return ERR_VEL_MAX;
            if (!skip[ERR_VEL_MIN - 1] && tv < lim(m, LIM_MINVEL)) return ERR_VEL_MIN;
            if (!skip[ERR_VEL_D1 - 1] &&
                beyond(tv - lv, period, lim(m, LIM_MAXACC), lim(m, LIM_MINACC)))
                return ERR_VEL_D1;
            if (!skip[ERR_VEL_FE - 1] &&
                ((tv > av) ? tv - av : av - tv) > lim(m, LIM_VELFE))
                return ERR_VEL_FE;
            return ERR_OK;
        end
        if (mode == MODE_CST) begin
            if (!skip[ERR_POS_MAX - 1] && ap > lim(m, LIM_MAXPOS)) return ERR_POS_MAX;
            if (!skip[ERR_POS_MIN - 1] && ap < lim(m, LIM_MINPOS)) return ERR_POS_MIN;
            if (!skip[ERR_VEL_MAX - 1] && av > lim(m, LIM_MAXVEL)) return ERR_VEL_MAX;
            if (!skip[ERR_VEL_MIN - 1] && av < lim(m, LIM_MINVEL)) return ERR_VEL_MIN;
            if (!skip[ERR_VEL_D1 - 1] &&
                beyond(av - lv, period, lim(m, LIM_MAXACC), lim(m, LIM_MINACC)))
                return ERR_VEL_D1;
            return ERR_OK;
        end
        if (!skip[ERR_MODE - 1]) return ERR_MODE;
        return ERR_OK;
    endfunction

    // Works out the result of one request and applies its effect on the state.
    function automatic t_verdict apply_request(logic [207:0] d);
        t_verdict          v;
        logic [1:0]        req;
        logic [3:0]        m;
        logic signed [7:0] mode;
        logic signed [31:0] tp;
        logic signed [31:0] tv;
        logic signed [31:0] ap;
        logic signed [31:0] lp;
        req  = d[1:0];
        m    = d[5:2];
        mode = d[64:57];
        tp   = d[96:65];
        tv   = d[128:97];
        ap   = d[160:129];
        lp   = last_pos[m];
        v    = '0;
        case (req)
            REQ_LOAD: begin
                limits[{m, d[8:6]}] = d[40:9];
            end
            REQ_CHECK: begin
                v.err = check_code(m, d[56:41], mode, longint'(tp), longint'(tv),
                                   longint'(ap), longint'($signed(d[192:161])),
                                   d[203:193]);
            end
            REQ_STORE: begin
                prev_pos[m] = last_pos[m];
                last_pos[m] = tp;
                last_vel[m] = tv;
            end
            default: begin
                if (mode == MODE_PP || mode == MODE_CSP) begin
                    // Keep the last command unless it has drifted past the
                    // following window, then snap to the measured position.
                    tp = ((lp > ap ? longint'(lp) - ap : longint'(ap) - lp) >
                          lim(m, LIM_POSFE)) ? ap : lp;
                end else if (mode == MODE_CSV) begin
                    tv = '0;
                end else if (mode == MODE_CST) begin
                    v.zt = 1'b1;
                    v.dis = 1'b1;
                end else begin
                    tp = '0;
                    tv = '0;
                    v.zt = 1'b1;
                    v.dis = 1'b1;
                end
                last_pos[m] = tp;
                prev_pos[m] = tp;
                last_vel[m] = tv;
                v.fp = tp;
                v.fv = tv;
            end
        endcase
        return v;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_results = 0;
    end

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            verdict_q.delete();
            period <= PERIOD_RESET;
            for (int i = 0; i < 16; i++) begin
                last_pos[i] = '0;
                prev_pos[i] = '0;
                last_vel[i] = '0;
            end
        end else begin
            if (i_cfg_we) period <= i_cfg_wdata;
            if (i_req_valid && i_req_ready) verdict_q.push_back(apply_request(i_req_data));
            if (i_res_valid && i_res_ready) begin
                o_results++;
                got = i_res_data[69:0];
                if (verdict_q.size() == 0) begin
                    report("unexpected result transfer", got.err, 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.err !== want.err) report("fault_code", got.err, want.err);
                    if (got.fp !== want.fp) report("fixed_pos", got.fp, want.fp);
                    if (got.fv !== want.fv) report("fixed_vel", got.fv, want.fv);
                    if (got.zt !== want.zt) report("zero_torque", got.zt, want.zt);
                    if (got.dis !== want.dis) report("disable_request", got.dis, want.dis);
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety monitor testbench top
// Drives requests and sample period writes into the monitor, toggles the
// result side ready at random, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top
    import mcsm_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int results;
    int cycles;
    int sent;

    // Set while neither side may idle at random.
    bit no_idle;
    // Set by the stimulus to make the result side hold off for a long time.
    bit hold_request;

    motion_command_safety_monitor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mcsm_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog: a run that hangs anywhere ends here.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Result side. Ready drops with a chance of eight in a hundred, except in
    // the quiet stretch. On request it holds ready low so that the output
    // register fills and the block stops taking requests.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 8);
            end
        end
    end

    // Fields are packed from bit 0 in the order of the port comment.
    function automatic logic [207:0] pack_req(logic [1:0] req, logic [3:0] motor,
                                              logic [2:0] sel, logic [31:0] lv,
                                              logic [15:0] sw, logic [7:0] mode,
                                              logic [31:0] tp, logic [31:0] tv,
                                              logic [31:0] ap, logic [31:0] av,
                                              logic [10:0] skip);
        return {4'd0, skip, av, ap, tv, tp, mode, sw, lv, sel, motor, req};
    endfunction

    // Offers one request, called at a falling edge, and returns at the falling
    // edge after the transfer. Valid stays high between back-to-back requests.
    task automatic send(logic [207:0] d);
        if (!no_idle && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // Period writes only happen once the block has drained.
    task automatic write_period(logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A limit that keeps most samples near the boundary of passing.
    function automatic logic [31:0] sane_limit(logic [2:0] sel);
        case (sel) inside
            LIM_MAXPOS, LIM_MAXVEL, LIM_MAXACC:
                return $urandom_range(32'h0100_0000, 32'h0000_1000);
            LIM_MINPOS, LIM_MINVEL, LIM_MINACC:
                return -$urandom_range(32'h0100_0000, 32'h0000_1000);
            default:
                return $urandom_range(32'h0080_0000, 32'h0000_0100);
        endcase
    endfunction

    // Mostly moderate values, sometimes anything the field holds.
    function automatic logic [31:0] any_value();
        if ($urandom_range(99) < 15) return $urandom;
        return $urandom_range(32'h0200_0000, 0) - 32'h0100_0000;
    endfunction

    function automatic logic [7:0] any_mode();
        case ($urandom_range(11))
            0:       return MODE_PP;
            1:       return MODE_HM;
            2, 3, 4: return MODE_CSP;
            5, 6, 7: return MODE_CSV;
            8, 9:    return MODE_CST;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic [1:0]  req;
        logic [2:0]  sel;
        logic [15:0] sw;
        logic [10:0] skip;
        int          pick;
        pick = $urandom_range(99);
        req = (pick < 10) ? REQ_LOAD : (pick < 55) ? REQ_CHECK :
              (pick < 85) ? REQ_STORE : REQ_FIX;
        sel = 3'($urandom_range(7));
        sw = ($urandom_range(9) != 0) ? 16'(($urandom & ~32'h0000_006f) | 32'h0000_0027)
                                      : 16'($urandom);
        pick = $urandom_range(9);
        skip = (pick < 6) ? 11'd0 : (pick < 9) ? (11'd1 << $urandom_range(10))
                                               : 11'($urandom);
        send(pack_req(req, 4'($urandom_range(15)), sel,
                      ($urandom_range(9) == 0) ? $urandom : sane_limit(sel),
                      sw, any_mode(), any_value(), any_value(), any_value(),
                      any_value(), skip));
    endtask

    initial begin
        logic [7:0]  modes [8];
        logic [31:0] periods [4];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        sent = 0;
        modes = '{MODE_PP, MODE_HM, MODE_CSP, MODE_CSV, MODE_CST, 8'sh00, 8'sh7f, 8'sh80};
        periods = '{32'd0, 32'hffff_ffff, $urandom, PERIOD_RESET};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every limit of every motor gets a value before anything reads it.
        for (int m = 0; m < 16; m++)
            for (int s = 0; s < 8; s++)
                send(pack_req(REQ_LOAD, 4'(m), 3'(s), sane_limit(3'(s)), '0, '0, '0, '0,
                              '0, '0, '0));

        // Directed part: extreme limits and values, not-enabled drive, all
        // skip bits set, and every mode through check and fix.
        send(pack_req(REQ_LOAD, 4'd15, LIM_MAXPOS, 32'h7fff_ffff, '0, '0, '0, '0, '0, '0, '0));
        send(pack_req(REQ_LOAD, 4'd15, LIM_MINPOS, 32'h8000_0000, '0, '0, '0, '0, '0, '0, '0));
        send(pack_req(REQ_STORE, 4'd15, '0, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000,
                      '0, '0, '0));
        send(pack_req(REQ_STORE, 4'd15, '0, '0, '0, '0, 32'h8000_0000, 32'h7fff_ffff,
                      '0, '0, '0));
        send(pack_req(REQ_CHECK, 4'd15, '0, '0, 16'h0000, MODE_CSP, '0, '0, '0, '0, 11'd0));
        send(pack_req(REQ_CHECK, 4'd15, '0, '0, 16'hffd0, MODE_CSP, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 11'h7ff));
        for (int i = 0; i < 8; i++) begin
            send(pack_req(REQ_CHECK, 4'd15, '0, '0, 16'hffb7, modes[i], 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 11'd0));
            send(pack_req(REQ_FIX, 4'd15, '0, '0, '0, modes[i], 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, '0, '0));
        end

        // Random part, one phase per period setting; the first phase runs
        // without any idling and the third with a long result hold-off.
        for (int p = 0; p < 5; p++) begin
            if (p > 0) write_period(periods[p - 1]);
            no_idle = (p == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 100) hold_request = 1'b1;
                send_random();
            end
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);

        $display("Sent %0d requests and checked %0d results over five sample periods,",
                 sent, results);
        $display("with all modes, skip masks, fixes and a long output stall.");
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mcsm_pkg.sv
rtl/core/mcsm_mul.sv
rtl/core/motion_command_safety_monitor.sv
rtl/core/mcsm_checker.sv
tb/mcsm_checker.sv
tb/tb_top.sv
